@@ rtl/fto_pkg.sv @@
// Shared constants, register codes and control structs for the flipbook tile offset keyer.
// No dependencies; every other file of the block imports this package.
package fto_pkg;

    localparam int FRAC_BITS  = 16;   // fraction bits of the offset values
    localparam int FRAME_BITS = 16;   // frame number bits taken from the input field

    localparam int FRAME_W    = 16;   // frame fields on the channels
    localparam int VAL_W      = 25;   // signed offset value
    localparam int COL_W      = 9;    // grid columns and rows
    localparam int START_W    = 16;
    localparam int TILES_W    = 17;
    localparam int HOLD_W     = 16;
    localparam int TILE_W     = 17;   // start tile plus pick
    localparam int DSR_W      = 17;   // widest divisor (tiles_used)
    localparam int DVD_W      = TILE_W + FRAC_BITS;  // widest dividend (row << FRAC_BITS)
    localparam int NU_W       = COL_W + FRAC_BITS;   // column offset << FRAC_BITS
    localparam int CNT_W      = $clog2(DVD_W + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic [VAL_W-1:0] MAG_LIMIT = VAL_W'(1) << (VAL_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRID_COLUMNS       = 3'd0,
        CFG_GRID_ROWS          = 3'd1,
        CFG_START_TILE         = 3'd2,
        CFG_TILES_USED         = 3'd3,
        CFG_HOLD_LENGTH        = 3'd4,
        CFG_WRAP_ENABLE        = 3'd5,
        CFG_NORMALIZED_OFFSETS = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dvd;    // dividend, MSB aligned
        logic [CNT_W-1:0] cnt;    // number of quotient bits
        logic [DSR_W-1:0] dsr;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quo;
        logic [DSR_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic                       start;
        logic [FRAME_BITS-1:0]      frame;
        logic [1:0][VAL_W-1:0]      val;
    } t_key_req;

    typedef struct packed {
        logic idle;
    } t_key_sts;

endpackage

@@ rtl/fto_frame_if.sv @@
// Frame number channel: valid/ready handshake carrying one frame per item.
// Depends on fto_pkg.
interface fto_frame_if;
    import fto_pkg::*;

    logic               valid;
    logic               ready;
    logic [FRAME_W-1:0] frame_number;

    modport source (output valid, output frame_number, input ready);
    modport sink   (input valid, input frame_number, output ready);
endinterface

@@ rtl/fto_key_if.sv @@
// Key channel: valid/ready handshake carrying one offset key per item.
// Depends on fto_pkg.
interface fto_key_if;
    import fto_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    axis;
    logic [FRAME_W-1:0]      key_frame;
    logic signed [VAL_W-1:0] key_value;
    logic                    run_end;

    modport source (output valid, output axis, output key_frame, output key_value,
                    output run_end, input ready);
    modport sink   (input valid, input axis, input key_frame, input key_value,
                    input run_end, output ready);
endinterface

@@ rtl/fto_div.sv @@
// Bit-serial restoring divider: shifts the dividend in one bit a cycle, one quotient bit out.
// Depends on fto_pkg.
module fto_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  fto_pkg::t_div_req  i_req,
    output fto_pkg::t_div_rsp  o_rsp
);
    import fto_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DSR_W-1:0] r_dsr;
    logic [DSR_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;

    logic [DSR_W:0]   trial;
    logic             ge;
    logic [DSR_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        ge    = trial >= {1'b0, r_dsr};
        n_rem = ge ? DSR_W'(trial - {1'b0, r_dsr}) : trial[DSR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.cnt;
                r_dvd  <= i_req.dvd;
                r_dsr  <= i_req.dsr;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_dvd <= r_dvd << 1;
                r_rem <= n_rem;
                r_quo <= {r_quo[DVD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

@@ rtl/fto_keyer.sv @@
// Per-axis key history and key emitter with an output register on the key channel.
// Depends on fto_pkg and fto_key_if.
module fto_keyer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fto_pkg::t_key_req i_req,
    output fto_pkg::t_key_sts o_sts,
    fto_key_if.source         o_key
);
    import fto_pkg::*;

    typedef enum logic {K_IDLE, K_EMIT} t_kstate;

    t_kstate                  r_state;
    logic [1:0]               r_has;
    logic [1:0][VAL_W-1:0]    r_last_val;
    logic [1:0][FRAME_BITS-1:0] r_last_frm;

    logic [3:0]               r_mask;   // hold U, new U, hold V, new V
    logic [1:0]               r_slot;
    logic [FRAME_BITS-1:0]    r_frame;
    logic [1:0][VAL_W-1:0]    r_new;
    logic [1:0][VAL_W-1:0]    r_old;

    logic                     r_ov;
    logic                     r_axis;
    logic [FRAME_BITS-1:0]    r_kf;
    logic [VAL_W-1:0]         r_kv;
    logic                     r_re;

    logic                     clear;
    logic [1:0]               has_eff;
    logic [1:0]               need;
    logic [1:0]               hold;
    logic [3:0]               mask;
    logic [FRAME_BITS-1:0]    prev_frame;
    logic [3:0]               rest;
    logic                     slot_on;
    logic                     out_free;
    logic                     load;
    logic                     advance;

    always_comb begin
        clear      = (i_req.frame == '0);
        prev_frame = FRAME_BITS'(i_req.frame - 1'b1);
        for (int c = 0; c < 2; c++) begin
            has_eff[c] = r_has[c] & ~clear;
            need[c]    = ~(has_eff[c] && (i_req.val[c] == r_last_val[c]));
            hold[c]    = need[c] && has_eff[c] && (r_last_frm[c] < prev_frame);
        end
        mask     = {need[1], hold[1], need[0], hold[0]};
        rest     = r_mask >> r_slot;
        slot_on  = rest[0];
        out_free = !r_ov || o_key.ready;
        load     = (r_state == K_EMIT) && slot_on && out_free;
        advance  = (r_state == K_EMIT) && (!slot_on || out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= K_IDLE;
            r_has      <= '0;
            r_last_val <= '0;
            r_last_frm <= '0;
            r_slot     <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (load) begin
                r_ov   <= 1'b1;
                r_axis <= r_slot[1];
                r_kf   <= r_slot[0] ? r_frame : FRAME_BITS'(r_frame - 1'b1);
                r_kv   <= r_slot[0] ? r_new[r_slot[1]] : r_old[r_slot[1]];
                r_re   <= (rest[3:1] == 3'd0);
            end else if (o_key.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                K_IDLE: begin
                    if (i_req.start) begin
                        r_mask  <= mask;
                        r_frame <= i_req.frame;
                        r_new   <= i_req.val;
                        r_old   <= r_last_val;
                        r_slot  <= '0;
                        for (int c = 0; c < 2; c++) begin
                            r_has[c] <= has_eff[c] | need[c];
                            if (need[c]) begin
                                r_last_val[c] <= i_req.val[c];
                                r_last_frm[c] <= i_req.frame;
                            end
                        end
                        if (mask != 4'd0) begin
                            r_state <= K_EMIT;
                        end
                    end
                end
                K_EMIT: begin
                    if (advance) begin
                        r_slot <= r_slot + 1'b1;
                        if (r_slot == 2'd3) begin
                            r_state <= K_IDLE;
                        end
                    end
                end
                default: r_state <= K_IDLE;
            endcase
        end
    end

    assign o_sts.idle      = (r_state == K_IDLE);
    assign o_key.valid     = r_ov;
    assign o_key.axis      = r_axis;
    assign o_key.key_frame = FRAME_W'(r_kf);
    assign o_key.key_value = r_kv;
    assign o_key.run_end   = r_re;

endmodule

@@ rtl/flipbook_tile_offset_keyer_top.sv @@
// Flipbook tile offset keyer: configuration registers, frame sequencer and key output.
// Depends on fto_pkg, fto_frame_if, fto_key_if, fto_div and fto_keyer.

// Takes one frame number at a time and emits zero to four U/V offset keys for it, U keys
// before V keys, run_end marking the last key of a frame. Every division (frame by hold
// length, step modulo tile count when wrapping, tile by columns, and in normalized mode
// the two offset scalings) runs through one shared radix-2 divider that retires one
// quotient bit per cycle; without wrapping the step is clamped to the last tile. A frame
// that emits any key walks the four key slots, and the key channel can stall the walk. A
// new frame is accepted once the last key of the previous one sits in the output register.
// Configuration must be written only while no frame is in flight; there is no clearing
// pass after reset.
module flipbook_tile_offset_keyer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fto_frame_if.sink                         i_frame,
    fto_key_if.source                         o_key,
    input  logic                              i_cfg_we,
    input  logic [fto_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [fto_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import fto_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_STEP, S_PICK, S_TILE, S_COL, S_NU, S_NV, S_KEY, S_WAIT
    } t_state;

    // configuration
    logic [COL_W-1:0]   r_cols;
    logic [COL_W-1:0]   r_rows;
    logic [START_W-1:0] r_start;
    logic [TILES_W-1:0] r_tiles;
    logic [HOLD_W-1:0]  r_hold;
    logic               r_wrap;
    logic               r_norm;

    t_state                   r_state;
    t_div_req                 r_div_req;
    logic [FRAME_BITS-1:0]    r_frame;
    logic [FRAME_BITS-1:0]    r_pick;
    logic [TILE_W-1:0]        r_whole_v;
    logic [1:0][DVD_W-1:0]    r_mag;

    t_div_rsp                 div_rsp;
    t_key_req                 key_req;
    t_key_sts                 key_sts;

    logic [COL_W-1:0]         cols_eff;
    logic [COL_W-1:0]         rows_eff;
    logic [TILES_W-1:0]       tiles_eff;
    logic [HOLD_W-1:0]        hold_eff;
    logic [FRAME_BITS-1:0]    step;
    logic [FRAME_BITS-1:0]    clamp_pick;
    logic [TILE_W-1:0]        tile;
    logic [NU_W-1:0]          nu;
    logic [DVD_W-1:0]         nv;
    logic [DVD_W-1:0]         dvd_step;
    logic [DVD_W-1:0]         dvd_pick;
    logic [DVD_W-1:0]         dvd_tile;
    logic [DVD_W-1:0]         dvd_nu;
    logic [1:0][VAL_W-1:0]    sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols  <= COL_W'(1);
            r_rows  <= COL_W'(1);
            r_start <= '0;
            r_tiles <= TILES_W'(1);
            r_hold  <= HOLD_W'(1);
            r_wrap  <= 1'b0;
            r_norm  <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_COLUMNS:       r_cols  <= i_cfg_data[COL_W-1:0];
                CFG_GRID_ROWS:          r_rows  <= i_cfg_data[COL_W-1:0];
                CFG_START_TILE:         r_start <= i_cfg_data[START_W-1:0];
                CFG_TILES_USED:         r_tiles <= i_cfg_data[TILES_W-1:0];
                CFG_HOLD_LENGTH:        r_hold  <= i_cfg_data[HOLD_W-1:0];
                CFG_WRAP_ENABLE:        r_wrap  <= i_cfg_data[0];
                CFG_NORMALIZED_OFFSETS: r_norm  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // a zero divisor acts as one
        cols_eff   = (r_cols  == '0) ? COL_W'(1)   : r_cols;
        rows_eff   = (r_rows  == '0) ? COL_W'(1)   : r_rows;
        tiles_eff  = (r_tiles == '0) ? TILES_W'(1) : r_tiles;
        hold_eff   = (r_hold  == '0) ? HOLD_W'(1)  : r_hold;

        step       = div_rsp.quo[FRAME_BITS-1:0];
        clamp_pick = (TILES_W'(step) < TILES_W'(tiles_eff - 1'b1)) ? step
                   : FRAME_BITS'(tiles_eff - 1'b1);
        tile       = TILE_W'(r_start) + TILE_W'(r_pick);
        // round to nearest by adding half the divisor
        nu         = (NU_W'(div_rsp.rem[COL_W-1:0]) << FRAC_BITS) + NU_W'(cols_eff >> 1);
        nv         = (DVD_W'(r_whole_v) << FRAC_BITS) + DVD_W'(rows_eff >> 1);

        dvd_step   = {i_frame.frame_number[FRAME_BITS-1:0], {(DVD_W-FRAME_BITS){1'b0}}};
        dvd_pick   = {step, {(DVD_W-FRAME_BITS){1'b0}}};
        dvd_tile   = {tile, {(DVD_W-TILE_W){1'b0}}};
        dvd_nu     = {nu, {(DVD_W-NU_W){1'b0}}};

        for (int c = 0; c < 2; c++) begin
            sat[c] = (r_mag[c] > DVD_W'(MAG_LIMIT)) ? MAG_LIMIT : r_mag[c][VAL_W-1:0];
            key_req.val[c] = VAL_W'('0 - sat[c]);
        end
        key_req.start = (r_state == S_KEY);
        key_req.frame = r_frame;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_div_req <= '0;
        end else begin
            r_div_req.start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_frame.valid) begin
                        r_frame   <= i_frame.frame_number[FRAME_BITS-1:0];
                        r_div_req <= '{start: 1'b1, dvd: dvd_step,
                                       cnt: CNT_W'(FRAME_BITS), dsr: DSR_W'(hold_eff)};
                        r_state   <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (div_rsp.done) begin
                        if (r_wrap) begin
                            r_div_req <= '{start: 1'b1, dvd: dvd_pick,
                                           cnt: CNT_W'(FRAME_BITS), dsr: DSR_W'(tiles_eff)};
                            r_state   <= S_PICK;
                        end else begin
                            r_pick  <= clamp_pick;
                            r_state <= S_TILE;
                        end
                    end
                end
                S_PICK: begin
                    if (div_rsp.done) begin
                        r_pick  <= div_rsp.rem[FRAME_BITS-1:0];
                        r_state <= S_TILE;
                    end
                end
                S_TILE: begin
                    r_div_req <= '{start: 1'b1, dvd: dvd_tile,
                                   cnt: CNT_W'(TILE_W), dsr: DSR_W'(cols_eff)};
                    r_state   <= S_COL;
                end
                S_COL: begin
                    if (div_rsp.done) begin
                        if (r_norm) begin
                            r_whole_v <= div_rsp.quo[TILE_W-1:0];
                            r_div_req <= '{start: 1'b1, dvd: dvd_nu,
                                           cnt: CNT_W'(NU_W), dsr: DSR_W'(cols_eff)};
                            r_state   <= S_NU;
                        end else begin
                            r_mag[0] <= DVD_W'(div_rsp.rem[COL_W-1:0]) << FRAC_BITS;
                            r_mag[1] <= DVD_W'(div_rsp.quo[TILE_W-1:0]) << FRAC_BITS;
                            r_state  <= S_KEY;
                        end
                    end
                end
                S_NU: begin
                    if (div_rsp.done) begin
                        r_mag[0]  <= div_rsp.quo;
                        r_div_req <= '{start: 1'b1, dvd: nv,
                                       cnt: CNT_W'(DVD_W), dsr: DSR_W'(rows_eff)};
                        r_state   <= S_NV;
                    end
                end
                S_NV: begin
                    if (div_rsp.done) begin
                        r_mag[1] <= div_rsp.quo;
                        r_state  <= S_KEY;
                    end
                end
                S_KEY: begin
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    // hold until the last key of this frame is in the output register
                    if (key_sts.idle) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_frame.ready = (r_state == S_IDLE);

    fto_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    fto_keyer u_keyer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (key_req),
        .o_sts   (key_sts),
        .o_key   (o_key)
    );

`ifndef SYNTHESIS
    a_key_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_req.start |-> key_sts.idle)
        else $error("key emitter started while still emitting");

    a_accept_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_frame.valid && i_frame.ready) |-> (key_sts.idle && !div_rsp.done))
        else $error("frame item accepted while earlier work is in flight");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_STEP || r_state == S_PICK || r_state == S_COL ||
                          r_state == S_NU || r_state == S_NV))
        else $error("divider finished outside a divide state");

    a_key_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEY) |=> (r_state == S_WAIT))
        else $error("sequencer skipped the key wait");
`endif

endmodule
